// File: rtl/core/mcd_pkg.sv
// shared types and constants for the mod-61 up/down counter with display
// no dependencies; used by every module and the channel interfaces
package mcd_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 8;
	localparam int unsigned CountW   = 7;
	localparam int unsigned TickW    = 8;
	localparam int unsigned SegW     = 7;
	localparam int unsigned LedW     = 8;

	localparam logic [CountW-1:0] MaxTop = 7'd99;

	// reset values of the configuration registers
	localparam logic [CountW-1:0] RstCountTop  = 7'd60;
	localparam logic [TickW-1:0]  RstSlowTicks = 8'd50;
	localparam logic [TickW-1:0]  RstFastTicks = 8'd20;
	localparam logic [TickW-1:0]  RstSlowHalf  = 8'd10;
	localparam logic [TickW-1:0]  RstFastHalf  = 8'd25;

	typedef enum logic [CfgIdxW-1:0] {
		REG_COUNT_TOP   = 3'd0,
		REG_SLOW_TICKS  = 3'd1,
		REG_FAST_TICKS  = 3'd2,
		REG_SLOW_HALVES = 3'd3,
		REG_FAST_HALVES = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [CountW-1:0] count_top;
		logic [TickW-1:0]  slow_ticks;
		logic [TickW-1:0]  fast_ticks;
		logic [TickW-1:0]  slow_halves;
		logic [TickW-1:0]  fast_halves;
	} cfg_t;

	// counter state as seen by the display logic
	typedef struct packed {
		logic [CountW-1:0] count;
		logic              blanked;
		logic              show_high;
		logic              in_blink;
	} disp_t;

	typedef struct packed {
		logic [SegW-1:0] segments;
		logic            low_digit_on;
		logic            high_digit_on;
		logic [LedW-1:0] leds;
		logic            blinking;
	} res_t;

endpackage

// File: rtl/core/mcd_ifs.sv
// valid/ready channel interfaces: tick input, display result, config write
// depends on mcd_pkg
interface mcd_in_if;
	logic valid;
	logic ready;
	logic switch_up;

	modport source(output valid, output switch_up, input ready);
	modport sink(input valid, input switch_up, output ready);
endinterface

interface mcd_out_if;
	logic                      valid;
	logic                      ready;
	logic [mcd_pkg::SegW-1:0]  segments;
	logic                      low_digit_on;
	logic                      high_digit_on;
	logic [mcd_pkg::LedW-1:0]  leds;
	logic                      blinking;

	modport source(output valid, output segments, output low_digit_on,
		output high_digit_on, output leds, output blinking, input ready);
	modport sink(input valid, input segments, input low_digit_on,
		input high_digit_on, input leds, input blinking, output ready);
endinterface

interface mcd_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mcd_pkg::CfgIdxW-1:0]   index;
	logic [mcd_pkg::CfgDataW-1:0]  data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mcd_cfg_regs.sv
// configuration register file, written through the config channel
// depends on mcd_pkg
module mcd_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [mcd_pkg::CfgIdxW-1:0]   wr_idx,
	input  logic [mcd_pkg::CfgDataW-1:0]  wr_data,
	output mcd_pkg::cfg_t                 cfg
);
	import mcd_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.count_top   <= RstCountTop;
			cfg_q.slow_ticks  <= RstSlowTicks;
			cfg_q.fast_ticks  <= RstFastTicks;
			cfg_q.slow_halves <= RstSlowHalf;
			cfg_q.fast_halves <= RstFastHalf;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_idx))
				REG_COUNT_TOP:   cfg_q.count_top   <= wr_data[CountW-1:0];
				REG_SLOW_TICKS:  cfg_q.slow_ticks  <= wr_data;
				REG_FAST_TICKS:  cfg_q.fast_ticks  <= wr_data;
				REG_SLOW_HALVES: cfg_q.slow_halves <= wr_data;
				REG_FAST_HALVES: cfg_q.fast_halves <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: rtl/core/mcd_counter.sv
// count, period timer and wrap blink state, advanced once per tick
// depends on mcd_pkg
module mcd_counter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          sw,
	input  mcd_pkg::cfg_t cfg,
	output mcd_pkg::disp_t disp
);
	import mcd_pkg::*;

	logic [CountW-1:0] count_q;
	logic              going_fast_q;
	logic [TickW-1:0]  tick_q;
	logic              in_blink_q;
	logic [TickW-1:0]  half_q;
	logic              blink_fast_q;
	logic              blanked_q;
	logic              show_high_q;

	logic [TickW-1:0]  limit_raw, limit, halves_raw, halves;
	logic [CountW-1:0] top;
	logic              period_end, last_half;

	always_comb begin
		if (in_blink_q)
			limit_raw = blink_fast_q ? cfg.fast_ticks : cfg.slow_ticks;
		else
			limit_raw = going_fast_q ? cfg.fast_ticks : cfg.slow_ticks;
		limit      = (limit_raw == '0) ? TickW'(1) : limit_raw;
		halves_raw = blink_fast_q ? cfg.fast_halves : cfg.slow_halves;
		halves     = (halves_raw == '0) ? TickW'(1) : halves_raw;
		top        = (cfg.count_top > MaxTop) ? MaxTop : cfg.count_top;
		period_end = ({1'b0, tick_q} + 9'd1) >= {1'b0, limit};
		last_half  = ({1'b0, half_q} + 9'd1) >= {1'b0, halves};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			going_fast_q <= 1'b0;
			tick_q       <= '0;
			in_blink_q   <= 1'b0;
			half_q       <= '0;
			blink_fast_q <= 1'b0;
			blanked_q    <= 1'b0;
			show_high_q  <= 1'b0;
		end else if (step) begin
			show_high_q <= !show_high_q;
			if (!period_end) begin
				tick_q <= tick_q + TickW'(1);
			end else begin
				tick_q <= '0;
				if (!in_blink_q) begin
					going_fast_q <= sw;
					if ((sw && count_q >= top) || (!sw && count_q == '0)) begin
						// wrap: start the blink phase dark
						count_q      <= sw ? '0 : top;
						in_blink_q   <= 1'b1;
						half_q       <= '0;
						blanked_q    <= 1'b1;
						blink_fast_q <= sw;
					end else begin
						count_q <= sw ? count_q + CountW'(1) : count_q - CountW'(1);
					end
				end else if (last_half) begin
					in_blink_q <= 1'b0;
					blanked_q  <= 1'b0;
					half_q     <= '0;
				end else begin
					half_q       <= half_q + TickW'(1);
					blanked_q    <= !blanked_q;
					blink_fast_q <= sw;
				end
			end
		end
	end

	assign disp.count     = count_q;
	assign disp.blanked   = blanked_q;
	assign disp.show_high = show_high_q;
	assign disp.in_blink  = in_blink_q;

	// blanking only happens inside the blink phase
	a_blank_in_blink: assert property (@(posedge clk) disable iff (!arst_n)
		blanked_q |-> in_blink_q)
		else $error("display blanked outside blink phase");

	// count never leaves the two-digit range
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxTop)
		else $error("count above 99");

	// tick timer stays below the largest period
	a_tick_range: assert property (@(posedge clk) disable iff (!arst_n)
		tick_q != '1)
		else $error("tick timer overflow");

	// digit select alternates on every tick
	a_digit_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (show_high_q != $past(show_high_q)))
		else $error("digit select did not alternate");

endmodule

// File: rtl/core/mcd_display.sv
// bcd digit split, seven-segment decode and digit enables
// depends on mcd_pkg
module mcd_display (
	input  mcd_pkg::disp_t disp,
	output mcd_pkg::res_t  res
);
	import mcd_pkg::*;

	function automatic logic [SegW-1:0] seg_code(input logic [3:0] d);
		logic [SegW-1:0] s;
		case (d)
			4'd0:    s = 7'h3F;
			4'd1:    s = 7'h06;
			4'd2:    s = 7'h5B;
			4'd3:    s = 7'h4F;
			4'd4:    s = 7'h66;
			4'd5:    s = 7'h6D;
			4'd6:    s = 7'h7D;
			4'd7:    s = 7'h07;
			4'd8:    s = 7'h7F;
			4'd9:    s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

	logic [14:0]       prod;
	logic [3:0]        quo, tens, ones, digit;
	logic [CountW-1:0] quo_x10;

	always_comb begin
		// divide by ten as multiply by 205 and shift, exact below 1029
		prod    = 15'(disp.count) * 15'd205;
		quo     = prod[14:11];
		quo_x10 = CountW'({3'b000, quo} * 7'd10);
		ones    = 4'((disp.count - quo_x10));
		tens    = (quo >= 4'd10) ? quo - 4'd10 : quo;
		digit   = disp.show_high ? tens : ones;

		res.segments      = seg_code(digit);
		res.low_digit_on  = !disp.show_high && !disp.blanked;
		res.high_digit_on = disp.show_high && !disp.blanked;
		res.leds          = {1'b0, disp.count};
		res.blinking      = disp.in_blink;
	end

endmodule

// File: rtl/core/mod61_updown_counter_display.sv
// up/down counter with multiplexed two-digit display; one item in, one item out
// pipeline: input stage, then result register; the result is registered
// throughput: one item per cycle, limited only by the output handshake
// reset: arst_n clears count, timers, blink state and both stages; registers take defaults
module mod61_updown_counter_display (
	input  logic       clk,
	input  logic       arst_n,
	mcd_in_if.sink     in_ch,
	mcd_out_if.source  out_ch,
	mcd_cfg_if.sink    cfg_ch
);
	import mcd_pkg::*;

	cfg_t  cfg;
	disp_t disp;
	res_t  res;

	logic valid_s1;
	logic switch_s1;
	logic out_valid_q;
	res_t res_q;

	logic advance;   // result register can take a new item
	logic step;      // the item in stage 1 is processed this cycle

	// config writes are always taken
	assign cfg_ch.ready = 1'b1;

	mcd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg_ch.valid),
		.wr_idx  (cfg_ch.index),
		.wr_data (cfg_ch.data),
		.cfg     (cfg)
	);

	// the result register frees up when empty or when taken this cycle
	assign advance     = !out_valid_q || out_ch.ready;
	assign step        = valid_s1 && advance;
	// stage 1 accepts a new item when empty or while its current one moves on
	assign in_ch.ready = !valid_s1 || advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready)
			switch_s1 <= in_ch.switch_up;
	end

	// state update; outputs reflect the state before this tick
	mcd_counter u_counter (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sw     (switch_s1),
		.cfg    (cfg),
		.disp   (disp)
	);

	mcd_display u_display (
		.disp (disp),
		.res  (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			res_q <= res;
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.segments      = res_q.segments;
	assign out_ch.low_digit_on  = res_q.low_digit_on;
	assign out_ch.high_digit_on = res_q.high_digit_on;
	assign out_ch.leds          = res_q.leds;
	assign out_ch.blinking      = res_q.blinking;

endmodule
